// ===== sv/nsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_pkg
// Shared field widths, result status codes and controller states for the
// nearest symbol lookup block.
// ----------------------------------------------------------------------------
package nsl_pkg;

  localparam int CMD_W    = 1;
  localparam int INDEX_W  = 12;
  localparam int RVA_W    = 32;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;

  // Command codes carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  // ST_HEADER reports the image header ("MZ") when the table is empty.
  typedef enum logic [STATUS_W-1:0] {
    ST_EXACT    = 2'd0,
    ST_DISP     = 2'd1,
    ST_HEADER   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_BACK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

// ===== sv/nsl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_if
// Channel interfaces of the nearest symbol lookup block: request items,
// result items and the symbol count register write.
// ----------------------------------------------------------------------------
interface nsl_req_if;
  logic                       valid;
  logic                       ready;
  logic [nsl_pkg::CMD_W-1:0]   cmd;
  logic [nsl_pkg::INDEX_W-1:0] entry_index;
  logic [nsl_pkg::RVA_W-1:0]   entry_rva;
  logic [nsl_pkg::RVA_W-1:0]   query_rva;

  modport source (output valid, output cmd, output entry_index, output entry_rva,
                  output query_rva, input ready);
  modport sink (input valid, input cmd, input entry_index, input entry_rva,
                input query_rva, output ready);
endinterface

interface nsl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nsl_pkg::STATUS_W-1:0] status;
  logic [nsl_pkg::INDEX_W-1:0]  symbol_index;
  logic [nsl_pkg::RVA_W-1:0]    displacement;

  modport source (output valid, output status, output symbol_index,
                  output displacement, input ready);
  modport sink (input valid, input status, input symbol_index,
                input displacement, output ready);
endinterface

interface nsl_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [nsl_pkg::COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/nearest_symbol_lookup_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_symbol_lookup_top
// Floor search over a sorted table of symbol addresses held in one
// synchronous memory, one probe per cycle.
// ----------------------------------------------------------------------------
// A write item is taken while the controller is idle. A query searches with at
// most ceil(log2(n + 1)) probes, n being symbol_count capped at TABLE_DEPTH,
// and one more read when the search steps back one entry; its result waits in
// S_EMIT while the output still holds an unaccepted result. No new item is taken
// until the result is loaded; each probe waits on the registered table read.
// Reset clears the controller, the symbol count and the result valid only.
module nearest_symbol_lookup_top #(
  parameter int TABLE_DEPTH = 4096
) (
  input logic       clk,
  input logic       rst,
  nsl_req_if.sink   req,
  nsl_rsp_if.source rsp,
  nsl_cfg_if.sink   cfg
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  nsl_pkg::state_t state;

  logic [nsl_pkg::COUNT_W-1:0] symbol_count;
  logic [nsl_pkg::RVA_W-1:0]   q;
  logic [CNT_W-1:0]            lo;
  logic [CNT_W-1:0]            hi;
  logic [AW-1:0]               mid;

  logic [nsl_pkg::RVA_W-1:0]   mem [TABLE_DEPTH];
  logic [nsl_pkg::RVA_W-1:0]   rd_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;

  nsl_pkg::status_t            res_status;
  logic [nsl_pkg::INDEX_W-1:0] res_index;
  logic [nsl_pkg::RVA_W-1:0]   res_disp;

  logic                        rsp_valid;
  nsl_pkg::status_t            rsp_status;
  logic [nsl_pkg::INDEX_W-1:0] rsp_index;
  logic [nsl_pkg::RVA_W-1:0]   rsp_disp;

  logic [31:0]      cnt_wide;
  logic [31:0]      hi_init_wide;
  logic [CNT_W-1:0] hi_init;
  logic [31:0]      widx_wide;
  logic             widx_ok;
  logic [31:0]      mid_wide;
  logic [nsl_pkg::INDEX_W-1:0] mid_index;
  logic             q_eq;
  logic             q_lt;
  logic [CNT_W-1:0] lo_next;
  logic [CNT_W-1:0] hi_next;
  logic [CNT_W:0]   sum;
  logic [AW-1:0]    mid_next;
  logic [AW-1:0]    mid_dec;
  logic             go_on;
  logic             req_xfer;
  logic             mem_we;
  logic             out_free;

  assign req.ready = (state == nsl_pkg::S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_xfer  = req.valid && req.ready;

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.symbol_index = rsp_index;
  assign rsp.displacement = rsp_disp;
  assign out_free         = !rsp_valid || rsp.ready;

  assign cnt_wide     = 32'(symbol_count);
  assign hi_init_wide = (cnt_wide > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_wide;
  assign hi_init      = hi_init_wide[CNT_W-1:0];

  assign widx_wide = 32'(req.entry_index);
  assign widx_ok   = widx_wide < 32'(TABLE_DEPTH);
  assign mem_we    = req_xfer && (req.cmd == nsl_pkg::CMD_WRITE) && widx_ok;

  assign mid_wide  = 32'(mid);
  assign mid_index = mid_wide[nsl_pkg::INDEX_W-1:0];
  assign mid_dec   = mid - AW'(1);

  assign q_eq = (q == rd_data);
  assign q_lt = (q < rd_data);

  always_comb begin
    if (state == nsl_pkg::S_CHECK) begin
      lo_next = q_lt ? lo : CNT_W'(mid) + CNT_W'(1);
      hi_next = q_lt ? CNT_W'(mid) : hi;
    end else begin
      lo_next = '0;
      hi_next = hi_init;
    end
  end

  assign sum      = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next = sum[AW:1];
  assign go_on    = lo_next < hi_next;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_next;
    case (state)
      nsl_pkg::S_IDLE: begin
        rd_en = req_xfer && (req.cmd == nsl_pkg::CMD_QUERY) && (hi_init != '0);
      end
      nsl_pkg::S_CHECK: begin
        if (!q_eq && go_on) begin
          rd_en = 1'b1;
        end else if (!q_eq && q_lt && (mid != '0)) begin
          rd_en   = 1'b1;
          rd_addr = mid_dec;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[widx_wide[AW-1:0]] <= req.entry_rva;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nsl_pkg::S_IDLE;
      symbol_count <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        symbol_count <= cfg.data;
      end
      if (rsp_valid && rsp.ready && (state != nsl_pkg::S_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        nsl_pkg::S_IDLE: begin
          if (req_xfer && (req.cmd == nsl_pkg::CMD_QUERY)) begin
            q <= req.query_rva;
            if (hi_init == '0) begin
              res_status <= nsl_pkg::ST_HEADER;
              res_index  <= '0;
              res_disp   <= req.query_rva;
              state      <= nsl_pkg::S_EMIT;
            end else begin
              lo    <= lo_next;
              hi    <= hi_next;
              mid   <= mid_next;
              state <= nsl_pkg::S_CHECK;
            end
          end
        end
        nsl_pkg::S_CHECK: begin
          if (q_eq) begin
            res_status <= nsl_pkg::ST_EXACT;
            res_index  <= mid_index;
            res_disp   <= '0;
            state      <= nsl_pkg::S_EMIT;
          end else if (go_on) begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= mid_next;
          end else if (q_lt) begin
            if (mid == '0) begin
              res_status <= nsl_pkg::ST_NOTFOUND;
              res_index  <= '0;
              res_disp   <= '0;
              state      <= nsl_pkg::S_EMIT;
            end else begin
              mid   <= mid_dec;
              state <= nsl_pkg::S_BACK;
            end
          end else begin
            res_status <= nsl_pkg::ST_DISP;
            res_index  <= mid_index;
            res_disp   <= q - rd_data;
            state      <= nsl_pkg::S_EMIT;
          end
        end
        nsl_pkg::S_BACK: begin
          res_status <= nsl_pkg::ST_DISP;
          res_index  <= mid_index;
          res_disp   <= q - rd_data;
          state      <= nsl_pkg::S_EMIT;
        end
        nsl_pkg::S_EMIT: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_index  <= res_index;
            rsp_disp   <= res_disp;
            state      <= nsl_pkg::S_IDLE;
          end
        end
        default: begin
          state <= nsl_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (32'(rd_addr) < 32'(TABLE_DEPTH)))
    else $error("table read beyond depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == nsl_pkg::S_CHECK) |-> (lo < hi) && (CNT_W'(mid) >= lo) && (CNT_W'(mid) < hi))
    else $error("probe outside search window");

  a_back_from_check: assert property (@(posedge clk) disable iff (rst)
    (state == nsl_pkg::S_BACK) |-> ($past(state) == nsl_pkg::S_CHECK) && $past(rd_en))
    else $error("step back without a read issued");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == nsl_pkg::S_EMIT) && out_free |=> rsp_valid && (state == nsl_pkg::S_IDLE))
    else $error("result not loaded on free output");

endmodule
